### design/bfd_pkg.sv
package bfd_pkg;

   // Width of the step shift register and its value after reset.
   localparam int unsigned STEP_SHIFT_BITS = 3;
   localparam logic [STEP_SHIFT_BITS-1:0] STEP_SHIFT_RESET = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_WALK = 3'b100
   } bfd_state_type;

   // Control from the sequencer to every coordinate lane.
   typedef struct packed {
      logic                       coef_en;  // latch segment coefficients
      logic                       load;     // load initial differences
      logic                       step;     // advance one forward difference step
      logic                       adv;      // output pipeline moves
      logic [STEP_SHIFT_BITS-1:0] k;        // clamped step shift
   } bfd_ctrl_type;

endpackage

### design/bfd_cell.sv
module bfd_cell #(
   parameter int DW = 40
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic                 step,
   input  logic signed [DW-1:0] init_value,
   input  logic signed [DW-1:0] next_value,
   output logic signed [DW-1:0] value
);

   logic signed [DW-1:0] value_ff;
   logic signed [DW-1:0] value_in;

   // Load the initial difference, or add the neighbor's difference.
   always_comb begin
      value_in = value_ff;
      if (load) begin
         value_in = init_value;
      end else if (step) begin
         value_in = value_ff + next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### design/bfd_round.sv
module bfd_round #(
   parameter int CW = 16,
   parameter int DW = 40
) (
   input  logic                  clock,
   input  bfd_pkg::bfd_ctrl_type ctrl,
   input  logic signed [DW-1:0]  f0,
   output logic signed [CW-1:0]  curve
);

   import bfd_pkg::*;

   // u = floor((F0 + S/2 + S*2^(CW-1)) / 2^(3k+1)), always non-negative;
   // the curve point is floor(u/3) - 2^(CW-1).
   localparam int UW = CW + 2;
   localparam int MW = CW + 2;
   localparam int PW = UW + MW;
   localparam int SH = CW + 3;
   localparam logic [DW-1:0] BIAS = DW'((64'd3 << CW) + 64'd3);
   localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'd2) / 64'd3);

   logic [4:0]    sh3;
   logic [DW-1:0] v;
   logic [UW-1:0] u_in;
   logic [UW-1:0] u_ff;
   logic [PW-1:0] prod;
   logic [CW-1:0] q;
   logic [CW-1:0] curve_in;
   logic [CW-1:0] curve_ff;

   assign sh3  = {2'b00, ctrl.k} + {1'b0, ctrl.k, 1'b0};
   assign v    = DW'(f0) + (BIAS << sh3);
   assign u_in = UW'(v >> (sh3 + 5'd1));

   // Divide by three with a reciprocal; exact for every u below 2^UW.
   assign prod     = {{MW{1'b0}}, u_ff} * {{UW{1'b0}}, RECIP};
   assign q        = prod[SH+CW-1:SH];
   assign curve_in = {~q[CW-1], q[CW-2:0]};

   always_ff @(posedge clock) begin
      if (ctrl.adv) begin
         u_ff     <= u_in;
         curve_ff <= curve_in;
      end
   end

   assign curve = signed'(curve_ff);

endmodule

### design/bfd_lane.sv
module bfd_lane #(
   parameter int CW      = 16,
   parameter int MAX_SHIFT = 5
) (
   input  logic                  clock,
   input  bfd_pkg::bfd_ctrl_type ctrl,
   input  logic signed [CW-1:0]  p0,
   input  logic signed [CW-1:0]  p1,
   input  logic signed [CW-1:0]  p2,
   input  logic signed [CW-1:0]  p3,
   output logic signed [CW-1:0]  curve
);

   import bfd_pkg::*;

   localparam int AW = CW + 4;
   localparam int DW = CW + 3 * MAX_SHIFT + 12;

   logic signed [AW-1:0] e0, e1, e2, e3;
   logic signed [AW-1:0] d12, s02, d20;
   logic signed [AW-1:0] ca_in, cb_in, cc_in, cd_in;
   logic signed [AW-1:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic signed [DW-1:0] xa, xb, xc, xd, xa6;
   logic [4:0]           sh1, sh2, sh3;
   logic signed [DW-1:0] f_init [4];
   logic signed [DW-1:0] f_val  [4];

   // Coefficients times six of the uniform cubic B-spline basis.
   assign e0  = AW'(p0);
   assign e1  = AW'(p1);
   assign e2  = AW'(p2);
   assign e3  = AW'(p3);
   assign d12 = e1 - e2;
   assign s02 = e0 + e2;
   assign d20 = e2 - e0;

   assign ca_in = e3 - e0 + (d12 <<< 1) + d12;
   assign cb_in = (s02 <<< 1) + s02 - (e1 <<< 2) - (e1 <<< 1);
   assign cc_in = (d20 <<< 1) + d20;
   assign cd_in = e0 + (e1 <<< 2) + e2;

   always_ff @(posedge clock) begin
      if (ctrl.coef_en) begin
         ca_ff <= ca_in;
         cb_ff <= cb_in;
         cc_ff <= cc_in;
         cd_ff <= cd_in;
      end
   end

   // Initial differences, all scaled by 6*2^(3k).
   assign xa  = DW'(ca_ff);
   assign xb  = DW'(cb_ff);
   assign xc  = DW'(cc_ff);
   assign xd  = DW'(cd_ff);
   assign xa6 = (xa <<< 2) + (xa <<< 1);
   assign sh1 = {2'b00, ctrl.k};
   assign sh2 = {1'b0, ctrl.k, 1'b0};
   assign sh3 = sh1 + sh2;

   assign f_init[0] = xd <<< sh3;
   assign f_init[1] = xa + (xb <<< sh1) + (xc <<< sh2);
   assign f_init[2] = xa6 + (xb <<< (sh1 + 5'd1));
   assign f_init[3] = xa6;

   for (genvar i = 0; i < 4; i++) begin : g_cell
      logic signed [DW-1:0] next_value;
      if (i == 3) begin : g_end
         assign next_value = '0;
      end else begin : g_mid
         assign next_value = f_val[i+1];
      end
      bfd_cell #(
         .DW (DW)
      ) u_cell (
         .clock      (clock),
         .load       (ctrl.load),
         .step       (ctrl.step),
         .init_value (f_init[i]),
         .next_value (next_value),
         .value      (f_val[i])
      );
   end

   bfd_round #(
      .CW (CW),
      .DW (DW)
   ) u_round (
      .clock (clock),
      .ctrl  (ctrl),
      .f0    (f_val[0]),
      .curve (curve)
   );

endmodule

### design/bspline_forward_difference_curve_top.sv
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/stall     point_x, point_y, point_z, curve_start
// rsp_      out        rsp_valid/stall     curve_x, curve_y, curve_z, segment_last
// csr_      in         csr_write_enable    step_shift (3 bits, reset 5)
//
// A control point that does not complete a window of four is stored and the
// block stays idle. A point that completes a window latches the coefficients,
// then loads the difference cells, then steps out one curve point at a time
// through the cell chain, 2^k + 1 points in all; k is the clamped step shift.
// Results reach the ports through a rounding stage and the output register;
// a stalled output freezes the whole walk.
// Reset is synchronous and clears control state only; no clearing pass.
module bspline_forward_difference_curve_top #(
   parameter int COORD_BITS     = 16,
   parameter int MAX_STEP_SHIFT = 5
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic                         req_curve_start,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_curve_x,
   output logic signed [COORD_BITS-1:0] rsp_curve_y,
   output logic signed [COORD_BITS-1:0] rsp_curve_z,
   output logic                         rsp_segment_last,

   input  logic                         csr_write_enable,
   input  logic [2:0]                   csr_write_data
);

   import bfd_pkg::*;

   localparam int CW = COORD_BITS;
   localparam int SW = MAX_STEP_SHIFT + 1;

   bfd_state_type              state_ff, state_in;
   logic [STEP_SHIFT_BITS-1:0] shift_ff;
   logic [STEP_SHIFT_BITS-1:0] k_eff;
   logic [1:0]                 held_ff, held_in, held_eff;
   logic [SW-1:0]              steps_ff, steps_in;
   logic                       s1_valid_ff, s1_last_ff;
   logic                       rsp_valid_ff, rsp_last_ff;
   logic                       accept;
   logic                       full_window;
   logic                       emit;
   logic                       last;
   logic                       adv;
   bfd_ctrl_type               ctrl;

   // Three held control points per coordinate; slot 0 is the oldest.
   logic signed [CW-1:0] win_x_ff [3];
   logic signed [CW-1:0] win_y_ff [3];
   logic signed [CW-1:0] win_z_ff [3];

   // Clamp the step shift to the supported range.
   always_comb begin
      k_eff = shift_ff;
      if (shift_ff == '0) begin
         k_eff = STEP_SHIFT_BITS'(1);
      end else if (shift_ff > STEP_SHIFT_BITS'(MAX_STEP_SHIFT)) begin
         k_eff = STEP_SHIFT_BITS'(MAX_STEP_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= STEP_SHIFT_RESET;
      end else if (csr_write_enable) begin
         shift_ff <= csr_write_data;
      end
   end

   // Take one point at a time; hold the input while a segment is in work.
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign held_eff    = req_curve_start ? 2'd0 : held_ff;
   assign full_window = (held_eff == 2'd3);

   // The output pipeline moves when the output register is free or taken.
   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign emit = (state_ff == ST_WALK) && adv;
   assign last = (steps_ff == '0);

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      steps_in = steps_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full_window) begin
                  state_in = ST_LOAD;
               end else begin
                  held_in = held_eff + 2'd1;
               end
            end
         end
         ST_LOAD: begin
            steps_in = SW'(1) << k_eff;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (emit) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  steps_in = steps_ff - SW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= 2'd0;
         steps_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         steps_ff <= steps_in;
         if (adv) begin
            s1_valid_ff  <= emit;
            s1_last_ff   <= emit && last;
            rsp_valid_ff <= s1_valid_ff;
            rsp_last_ff  <= s1_last_ff;
         end
      end
   end

   // Fill the window, or slide it once the segment's coefficients are taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (full_window) begin
            win_x_ff[0] <= win_x_ff[1];
            win_y_ff[0] <= win_y_ff[1];
            win_z_ff[0] <= win_z_ff[1];
            win_x_ff[1] <= win_x_ff[2];
            win_y_ff[1] <= win_y_ff[2];
            win_z_ff[1] <= win_z_ff[2];
            win_x_ff[2] <= req_point_x;
            win_y_ff[2] <= req_point_y;
            win_z_ff[2] <= req_point_z;
         end else begin
            win_x_ff[held_eff] <= req_point_x;
            win_y_ff[held_eff] <= req_point_y;
            win_z_ff[held_eff] <= req_point_z;
         end
      end
   end

   assign ctrl.coef_en = accept && full_window;
   assign ctrl.load    = (state_ff == ST_LOAD);
   assign ctrl.step    = emit;
   assign ctrl.adv     = adv;
   assign ctrl.k       = k_eff;

   bfd_lane #(
      .CW        (CW),
      .MAX_SHIFT (MAX_STEP_SHIFT)
   ) u_lane_x (
      .clock (clock),
      .ctrl  (ctrl),
      .p0    (win_x_ff[0]),
      .p1    (win_x_ff[1]),
      .p2    (win_x_ff[2]),
      .p3    (req_point_x),
      .curve (rsp_curve_x)
   );

   bfd_lane #(
      .CW        (CW),
      .MAX_SHIFT (MAX_STEP_SHIFT)
   ) u_lane_y (
      .clock (clock),
      .ctrl  (ctrl),
      .p0    (win_y_ff[0]),
      .p1    (win_y_ff[1]),
      .p2    (win_y_ff[2]),
      .p3    (req_point_y),
      .curve (rsp_curve_y)
   );

   bfd_lane #(
      .CW        (CW),
      .MAX_SHIFT (MAX_STEP_SHIFT)
   ) u_lane_z (
      .clock (clock),
      .ctrl  (ctrl),
      .p0    (win_z_ff[0]),
      .p1    (win_z_ff[1]),
      .p2    (win_z_ff[2]),
      .p3    (req_point_z),
      .curve (rsp_curve_z)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segment_last = rsp_last_ff;

endmodule
